// ----- hw/rtl/steq_pkg.sv -----
// ----------------------------------------------------------------------------
// steq_pkg
// Shared types and constants for the sorted timer event queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package steq_pkg;

   // Queue geometry
   localparam int QDEPTH = 32;
   localparam int CNT_W  = $clog2(QDEPTH + 1);
   localparam int IDX_W  = $clog2(QDEPTH);

   // Field widths
   localparam int OP_W   = 2;
   localparam int DLY_W  = 24;
   localparam int HND_W  = 4;
   localparam int DAT_W  = 16;
   localparam int TIME_W = 32;
   localparam int STS_W  = 3;

   // Opcodes
   localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL  = 2'd1;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

   // Result status codes
   localparam logic [STS_W-1:0] ST_DONE       = 3'd0;
   localparam logic [STS_W-1:0] ST_FIRED      = 3'd1;
   localparam logic [STS_W-1:0] ST_FIRED_NOH  = 3'd2;
   localparam logic [STS_W-1:0] ST_FULL       = 3'd3;
   localparam logic [STS_W-1:0] ST_NOT_FOUND  = 3'd4;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_CANCEL,
      S_FIRE,
      S_QUERY
   } state_type;

   // Kind of result beat to build
   typedef enum logic [2:0] {
      RK_DONE,
      RK_FULL,
      RK_NOT_FOUND,
      RK_FIRE,
      RK_REMAIN
   } rkind_type;

   // Controller -> datapath
   typedef struct packed {
      logic      load;
      logic      inc;
      logic      insert;
      logic      remove;
      logic      set_time;
      logic      emit;
      rkind_type kind;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic idx_lt_cnt;
      logic full;
      logic cnt_nz;
      logic rd_lt_due;
      logic rd_le_time;
      logic cancel_match;
      logic query_match;
      logic out_ready;
   } stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/steq_dp.sv -----
// ----------------------------------------------------------------------------
// steq_dp
// Queue storage, scan pointer, compare logic and result beat register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module steq_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire steq_pkg::cmd_type              cmd,
   output steq_pkg::stat_type                  stat,
   input  wire logic [steq_pkg::DLY_W-1:0]     req_delay,
   input  wire logic [steq_pkg::HND_W-1:0]     req_handler_id,
   input  wire logic [steq_pkg::DAT_W-1:0]     req_data_handle,
   input  wire logic [steq_pkg::TIME_W-1:0]    req_new_time,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [steq_pkg::STS_W-1:0]          rsp_status,
   output logic [steq_pkg::HND_W-1:0]          rsp_fired_handler,
   output logic [steq_pkg::DAT_W-1:0]          rsp_fired_data,
   output logic [steq_pkg::TIME_W-1:0]         rsp_fired_time,
   output logic [steq_pkg::DLY_W-1:0]          rsp_remaining,
   output logic                                rsp_last
);

   // Queue entries, kept in ascending due order
   logic [steq_pkg::TIME_W-1:0] due_ff [steq_pkg::QDEPTH];
   logic [steq_pkg::HND_W-1:0]  hnd_ff [steq_pkg::QDEPTH];
   logic [steq_pkg::DAT_W-1:0]  dat_ff [steq_pkg::QDEPTH];

   logic [steq_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [steq_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [steq_pkg::TIME_W-1:0] cur_ff, cur_in;

   // Latched request
   logic [steq_pkg::TIME_W-1:0] new_due_ff;
   logic [steq_pkg::TIME_W-1:0] ntime_ff;
   logic [steq_pkg::HND_W-1:0]  hid_ff;
   logic [steq_pkg::DAT_W-1:0]  dh_ff;

   // Output beat
   logic                        ovld_ff, ovld_in;
   logic [steq_pkg::STS_W-1:0]  osts_ff;
   logic [steq_pkg::HND_W-1:0]  ohnd_ff;
   logic [steq_pkg::DAT_W-1:0]  odat_ff;
   logic [steq_pkg::TIME_W-1:0] otim_ff;
   logic [steq_pkg::DLY_W-1:0]  orem_ff;
   logic                        olast_ff;

   logic [steq_pkg::IDX_W-1:0]  ridx;
   logic [steq_pkg::TIME_W-1:0] rd_due;
   logic [steq_pkg::HND_W-1:0]  rd_hnd;
   logic [steq_pkg::DAT_W-1:0]  rd_dat;
   logic [steq_pkg::TIME_W-1:0] diff;
   logic [steq_pkg::DLY_W-1:0]  rem_sat;

   // Read the entry under the scan pointer
   assign ridx   = idx_ff[steq_pkg::IDX_W-1:0];
   assign rd_due = due_ff[ridx];
   assign rd_hnd = hnd_ff[ridx];
   assign rd_dat = dat_ff[ridx];

   // Remaining time, saturated
   assign diff    = rd_due - cur_ff;
   assign rem_sat = (diff[steq_pkg::TIME_W-1:steq_pkg::DLY_W] != '0) ? '1
                                                                    : diff[steq_pkg::DLY_W-1:0];

   // Status to controller
   always_comb begin
      stat.idx_lt_cnt   = idx_ff < cnt_ff;
      stat.full         = cnt_ff == steq_pkg::CNT_W'(steq_pkg::QDEPTH);
      stat.cnt_nz       = cnt_ff != '0;
      stat.rd_lt_due    = rd_due < new_due_ff;
      stat.rd_le_time   = rd_due <= ntime_ff;
      stat.cancel_match = ((hid_ff == '0) || (rd_hnd == hid_ff)) && (rd_dat == dh_ff);
      stat.query_match  = (rd_hnd == hid_ff) && (rd_dat == dh_ff);
      stat.out_ready    = !ovld_ff || !rsp_stall;
   end

   // Control register next values
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      cur_in = cur_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.insert) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.remove) begin
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.set_time) begin
         cur_in = ntime_ff;
      end
      ovld_in = ovld_ff && rsp_stall;
      if (cmd.emit) begin
         ovld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         idx_ff  <= '0;
         cur_ff  <= '0;
         ovld_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         idx_ff  <= idx_in;
         cur_ff  <= cur_in;
         ovld_ff <= ovld_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         new_due_ff <= cur_ff + steq_pkg::TIME_W'(req_delay);
         ntime_ff   <= req_new_time;
         hid_ff     <= req_handler_id;
         dh_ff      <= req_data_handle;
      end
   end

   // Entry shifting: open a hole at the pointer, or close it
   always_ff @(posedge clock) begin
      for (int i = 0; i < steq_pkg::QDEPTH; i++) begin
         if (cmd.insert) begin
            if (i == int'(idx_ff)) begin
               due_ff[i] <= new_due_ff;
               hnd_ff[i] <= hid_ff;
               dat_ff[i] <= dh_ff;
            end else if (i > int'(idx_ff)) begin
               due_ff[i] <= due_ff[i-1];
               hnd_ff[i] <= hnd_ff[i-1];
               dat_ff[i] <= dat_ff[i-1];
            end
         end else if (cmd.remove) begin
            if ((i >= int'(idx_ff)) && (i < steq_pkg::QDEPTH - 1)) begin
               due_ff[i] <= due_ff[i+1];
               hnd_ff[i] <= hnd_ff[i+1];
               dat_ff[i] <= dat_ff[i+1];
            end
         end
      end
   end

   // Result beat register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         osts_ff  <= steq_pkg::ST_DONE;
         ohnd_ff  <= '0;
         odat_ff  <= '0;
         otim_ff  <= '0;
         orem_ff  <= '0;
         olast_ff <= 1'b1;
         case (cmd.kind)
            steq_pkg::RK_FULL: begin
               osts_ff <= steq_pkg::ST_FULL;
            end
            steq_pkg::RK_NOT_FOUND: begin
               osts_ff <= steq_pkg::ST_NOT_FOUND;
            end
            steq_pkg::RK_FIRE: begin
               osts_ff  <= (rd_hnd != '0) ? steq_pkg::ST_FIRED : steq_pkg::ST_FIRED_NOH;
               ohnd_ff  <= rd_hnd;
               odat_ff  <= rd_dat;
               otim_ff  <= rd_due;
               olast_ff <= 1'b0;
            end
            steq_pkg::RK_REMAIN: begin
               orem_ff <= rem_sat;
            end
            default: begin
               osts_ff <= steq_pkg::ST_DONE;
            end
         endcase
      end
   end

   assign rsp_valid         = ovld_ff;
   assign rsp_status        = osts_ff;
   assign rsp_fired_handler = ohnd_ff;
   assign rsp_fired_data    = odat_ff;
   assign rsp_fired_time    = otim_ff;
   assign rsp_remaining     = orem_ff;
   assign rsp_last          = olast_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/steq_ctrl.sv -----
// ----------------------------------------------------------------------------
// steq_ctrl
// Sequencer for add, cancel, advance and query scans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module steq_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [steq_pkg::OP_W-1:0]   req_opcode,
   output logic                             req_stall,
   input  wire steq_pkg::stat_type          stat,
   output steq_pkg::cmd_type                cmd
);

   steq_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= steq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.kind     = steq_pkg::RK_DONE;
      req_stall    = state_ff != steq_pkg::S_IDLE;
      case (state_ff)
         steq_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_opcode)
                  steq_pkg::OP_ADD:     state_in = steq_pkg::S_ADD;
                  steq_pkg::OP_CANCEL:  state_in = steq_pkg::S_CANCEL;
                  steq_pkg::OP_ADVANCE: state_in = steq_pkg::S_FIRE;
                  default:              state_in = steq_pkg::S_QUERY;
               endcase
            end
         end
         // find first entry not earlier than the new due time
         steq_pkg::S_ADD: begin
            if (stat.full) begin
               if (stat.out_ready) begin
                  cmd.emit = 1'b1;
                  cmd.kind = steq_pkg::RK_FULL;
                  state_in = steq_pkg::S_IDLE;
               end
            end else if (stat.idx_lt_cnt && stat.rd_lt_due) begin
               cmd.inc = 1'b1;
            end else if (stat.out_ready) begin
               cmd.insert = 1'b1;
               cmd.emit   = 1'b1;
               state_in   = steq_pkg::S_IDLE;
            end
         end
         // drop matches in place, keep order
         steq_pkg::S_CANCEL: begin
            if (stat.idx_lt_cnt) begin
               if (stat.cancel_match) begin
                  cmd.remove = 1'b1;
               end else begin
                  cmd.inc = 1'b1;
               end
            end else if (stat.out_ready) begin
               cmd.emit = 1'b1;
               state_in = steq_pkg::S_IDLE;
            end
         end
         // pop head while due, one beat each
         steq_pkg::S_FIRE: begin
            if (stat.out_ready) begin
               cmd.emit = 1'b1;
               if (stat.cnt_nz && stat.rd_le_time) begin
                  cmd.kind   = steq_pkg::RK_FIRE;
                  cmd.remove = 1'b1;
               end else begin
                  cmd.set_time = 1'b1;
                  state_in     = steq_pkg::S_IDLE;
               end
            end
         end
         // first exact match
         steq_pkg::S_QUERY: begin
            if (stat.idx_lt_cnt && !stat.query_match) begin
               cmd.inc = 1'b1;
            end else if (stat.out_ready) begin
               cmd.emit = 1'b1;
               cmd.kind = stat.idx_lt_cnt ? steq_pkg::RK_REMAIN : steq_pkg::RK_NOT_FOUND;
               state_in = steq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = steq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_timer_event_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_core
// Time-ordered event queue with add, cancel, advance and query.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/stall    | opcode, delay, handler_id, data_handle,
//          |     |                    | new_time
//  rsp     | out | rsp_valid/stall    | status, fired_handler, fired_data,
//          |     |                    | fired_time, remaining, last
//
// One request at a time; req_stall is high from acceptance until the last
// beat is loaded into the output register. Add, cancel and query step the
// single scan pointer one entry at a time; advance emits one beat per fired
// entry plus a closing done beat. Synchronous reset empties the queue and
// zeroes current time. rsp_stall holds the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_event_queue_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [steq_pkg::OP_W-1:0]      req_opcode,
   input  wire logic [steq_pkg::DLY_W-1:0]     req_delay,
   input  wire logic [steq_pkg::HND_W-1:0]     req_handler_id,
   input  wire logic [steq_pkg::DAT_W-1:0]     req_data_handle,
   input  wire logic [steq_pkg::TIME_W-1:0]    req_new_time,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [steq_pkg::STS_W-1:0]          rsp_status,
   output logic [steq_pkg::HND_W-1:0]          rsp_fired_handler,
   output logic [steq_pkg::DAT_W-1:0]          rsp_fired_data,
   output logic [steq_pkg::TIME_W-1:0]         rsp_fired_time,
   output logic [steq_pkg::DLY_W-1:0]          rsp_remaining,
   output logic                                rsp_last
);

   steq_pkg::cmd_type  cmd;
   steq_pkg::stat_type stat;

   steq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   steq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_delay         (req_delay),
      .req_handler_id    (req_handler_id),
      .req_data_handle   (req_data_handle),
      .req_new_time      (req_new_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_fired_data    (rsp_fired_data),
      .rsp_fired_time    (rsp_fired_time),
      .rsp_remaining     (rsp_remaining),
      .rsp_last          (rsp_last)
   );

   // Accepted request makes the sequencer busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer not busy after accept");

   // Never overwrite a beat still waiting
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_ready)
      else $error("beat overwritten");

   // No insert into a full queue
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !stat.full)
      else $error("insert into full queue");

   // Insert and remove exclusive
   a_shift_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.remove))
      else $error("insert and remove together");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted timer event queue: a queue-based driver
// and a clocked monitor compare every result beat with a behavioral model of
// the sorted queue, across several idle/stall phases and a long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [steq_pkg::OP_W-1:0]   opcode;
      logic [steq_pkg::DLY_W-1:0]  delay;
      logic [steq_pkg::HND_W-1:0]  handler_id;
      logic [steq_pkg::DAT_W-1:0]  data_handle;
      logic [steq_pkg::TIME_W-1:0] new_time;
   } req_beat_type;

   typedef struct packed {
      logic [steq_pkg::STS_W-1:0]  status;
      logic [steq_pkg::HND_W-1:0]  fired_handler;
      logic [steq_pkg::DAT_W-1:0]  fired_data;
      logic [steq_pkg::TIME_W-1:0] fired_time;
      logic [steq_pkg::DLY_W-1:0]  remaining;
      logic                        last;
   } rsp_beat_type;

   localparam int LIMIT_CYCLES = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [steq_pkg::OP_W-1:0]   req_opcode = '0;
   logic [steq_pkg::DLY_W-1:0]  req_delay = '0;
   logic [steq_pkg::HND_W-1:0]  req_handler_id = '0;
   logic [steq_pkg::DAT_W-1:0]  req_data_handle = '0;
   logic [steq_pkg::TIME_W-1:0] req_new_time = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [steq_pkg::STS_W-1:0]  rsp_status;
   logic [steq_pkg::HND_W-1:0]  rsp_fired_handler;
   logic [steq_pkg::DAT_W-1:0]  rsp_fired_data;
   logic [steq_pkg::TIME_W-1:0] rsp_fired_time;
   logic [steq_pkg::DLY_W-1:0]  rsp_remaining;
   logic rsp_last;

   sorted_timer_event_queue_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_delay(req_delay),
      .req_handler_id(req_handler_id), .req_data_handle(req_data_handle),
      .req_new_time(req_new_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_fired_handler(rsp_fired_handler),
      .rsp_fired_data(rsp_fired_data), .rsp_fired_time(rsp_fired_time),
      .rsp_remaining(rsp_remaining), .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model of the event queue
   logic [steq_pkg::TIME_W-1:0] ev_due [steq_pkg::QDEPTH];
   logic [steq_pkg::HND_W-1:0]  ev_hnd [steq_pkg::QDEPTH];
   logic [steq_pkg::DAT_W-1:0]  ev_dat [steq_pkg::QDEPTH];
   int                          ev_count = 0;
   logic [steq_pkg::TIME_W-1:0] now_time = '0;

   req_beat_type pending_reqs[$];
   rsp_beat_type expected_rsps[$];

   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 1'b0;
   int  hold_cycles = 0;
   bit  req_taken = 1'b0;
   longint cycle_count = 0;

   // Used by the generator to aim queries/cancels at live entries
   logic [steq_pkg::HND_W-1:0] gen_hnd [steq_pkg::QDEPTH];
   logic [steq_pkg::DAT_W-1:0] gen_dat [steq_pkg::QDEPTH];
   int gen_count = 0;

   function automatic rsp_beat_type make_rsp(logic [steq_pkg::STS_W-1:0] st,
                                             logic [steq_pkg::HND_W-1:0] h,
                                             logic [steq_pkg::DAT_W-1:0] d,
                                             logic [steq_pkg::TIME_W-1:0] t,
                                             logic [steq_pkg::DLY_W-1:0] rem,
                                             logic fin);
      rsp_beat_type r;
      r.status = st; r.fired_handler = h; r.fired_data = d;
      r.fired_time = t; r.remaining = rem; r.last = fin;
      return r;
   endfunction

   task automatic drop_event(int pos);
      for (int i = pos; i + 1 < ev_count; i++) begin
         ev_due[i] = ev_due[i+1]; ev_hnd[i] = ev_hnd[i+1]; ev_dat[i] = ev_dat[i+1];
      end
      ev_count--;
   endtask

   // Applies one accepted request to the model and queues its result beats
   task automatic predict_queue_results(req_beat_type q);
      logic [steq_pkg::TIME_W-1:0] due;
      logic [steq_pkg::TIME_W-1:0] diff;
      int pos;
      bit found;
      found = 1'b0;
      case (q.opcode)
         steq_pkg::OP_ADD: begin
            if (ev_count >= steq_pkg::QDEPTH) begin
               expected_rsps.push_back(make_rsp(steq_pkg::ST_FULL, '0, '0, '0, '0, 1'b1));
            end else begin
               due = now_time + steq_pkg::TIME_W'(q.delay);
               pos = 0;
               while (pos < ev_count && ev_due[pos] < due) pos++;
               for (int i = ev_count; i > pos; i--) begin
                  ev_due[i] = ev_due[i-1]; ev_hnd[i] = ev_hnd[i-1]; ev_dat[i] = ev_dat[i-1];
               end
               ev_due[pos] = due; ev_hnd[pos] = q.handler_id; ev_dat[pos] = q.data_handle;
               ev_count++;
               expected_rsps.push_back(make_rsp(steq_pkg::ST_DONE, '0, '0, '0, '0, 1'b1));
            end
         end
         steq_pkg::OP_CANCEL: begin
            pos = 0;
            while (pos < ev_count) begin
               if ((q.handler_id == '0 || ev_hnd[pos] == q.handler_id) &&
                   ev_dat[pos] == q.data_handle)
                  drop_event(pos);
               else
                  pos++;
            end
            expected_rsps.push_back(make_rsp(steq_pkg::ST_DONE, '0, '0, '0, '0, 1'b1));
         end
         steq_pkg::OP_ADVANCE: begin
            while (ev_count > 0 && ev_due[0] <= q.new_time) begin
               expected_rsps.push_back(make_rsp(
                  (ev_hnd[0] != '0) ? steq_pkg::ST_FIRED : steq_pkg::ST_FIRED_NOH,
                  ev_hnd[0], ev_dat[0], ev_due[0], '0, 1'b0));
               drop_event(0);
            end
            now_time = q.new_time;
            expected_rsps.push_back(make_rsp(steq_pkg::ST_DONE, '0, '0, '0, '0, 1'b1));
         end
         default: begin
            for (int i = 0; i < ev_count && !found; i++) begin
               if (ev_hnd[i] == q.handler_id && ev_dat[i] == q.data_handle) begin
                  found = 1'b1;
                  diff = ev_due[i] - now_time;
                  if (diff > 32'h00FF_FFFF) diff = 32'h00FF_FFFF;
                  expected_rsps.push_back(make_rsp(steq_pkg::ST_DONE, '0, '0, '0,
                                                   diff[steq_pkg::DLY_W-1:0], 1'b1));
               end
            end
            if (!found)
               expected_rsps.push_back(make_rsp(steq_pkg::ST_NOT_FOUND, '0, '0, '0, '0,
                                                1'b1));
         end
      endcase
   endtask

   // Driver: presents queued beats, changes inputs on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid       <= 1'b1;
               req_opcode      <= pending_reqs[0].opcode;
               req_delay       <= pending_reqs[0].delay;
               req_handler_id  <= pending_reqs[0].handler_id;
               req_data_handle <= pending_reqs[0].data_handle;
               req_new_time    <= pending_reqs[0].new_time;
               void'(pending_reqs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long counted hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
         end else if (hold_off) begin
            rsp_stall <= 1'b1;
            hold_cycles <= 400;
            hold_off <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Monitor: accepts beats on the rising edge, predicts and checks
   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall)
            predict_queue_results({req_opcode, req_delay, req_handler_id,
                                   req_data_handle, req_new_time});
         if (rsp_valid && !rsp_stall) begin
            got = make_rsp(rsp_status, rsp_fired_handler, rsp_fired_data,
                           rsp_fired_time, rsp_remaining, rsp_last);
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat %h", $time, got);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) begin
                  errors++;
                  $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
               end
               if (got.fired_handler !== want.fired_handler) begin
                  errors++;
                  $display("%0t: fired_handler exp %0d got %0d", $time,
                           want.fired_handler, got.fired_handler);
               end
               if (got.fired_data !== want.fired_data) begin
                  errors++;
                  $display("%0t: fired_data exp %h got %h", $time,
                           want.fired_data, got.fired_data);
               end
               if (got.fired_time !== want.fired_time) begin
                  errors++;
                  $display("%0t: fired_time exp %h got %h", $time,
                           want.fired_time, got.fired_time);
               end
               if (got.remaining !== want.remaining) begin
                  errors++;
                  $display("%0t: remaining exp %h got %h", $time,
                           want.remaining, got.remaining);
               end
               if (got.last !== want.last) begin
                  errors++;
                  $display("%0t: last exp %b got %b", $time, want.last, got.last);
               end
            end
         end
      end
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic req_beat_type make_req(logic [steq_pkg::OP_W-1:0] op,
                                             logic [steq_pkg::DLY_W-1:0] dly,
                                             logic [steq_pkg::HND_W-1:0] h,
                                             logic [steq_pkg::DAT_W-1:0] d,
                                             logic [steq_pkg::TIME_W-1:0] t);
      req_beat_type q;
      q.opcode = op; q.delay = dly; q.handler_id = h; q.data_handle = d; q.new_time = t;
      return q;
   endfunction

   // Random item, biased toward keys that are in the queue
   task automatic push_random_item(ref logic [steq_pkg::TIME_W-1:0] gen_time);
      int sel;
      int k;
      logic [steq_pkg::HND_W-1:0]  h;
      logic [steq_pkg::DAT_W-1:0]  d;
      logic [steq_pkg::DLY_W-1:0]  dly;
      logic [steq_pkg::DLY_W-1:0]  rnd_dly;
      logic [steq_pkg::TIME_W-1:0] rnd_time;
      logic [steq_pkg::TIME_W-1:0] t;
      sel = int'($urandom_range(99));
      h = steq_pkg::HND_W'($urandom_range(15));
      d = steq_pkg::DAT_W'($urandom_range(7));
      rnd_dly = steq_pkg::DLY_W'($urandom);
      rnd_time = $urandom;
      if ($urandom_range(9) == 0) d = steq_pkg::DAT_W'($urandom);
      if (gen_count > 0 && $urandom_range(2) != 0) begin
         k = int'($urandom_range(gen_count - 1));
         h = gen_hnd[k]; d = gen_dat[k];
      end
      case ($urandom_range(3))
         0: dly = steq_pkg::DLY_W'($urandom);
         1: dly = steq_pkg::DLY_W'($urandom_range(2000));
         default: dly = steq_pkg::DLY_W'($urandom_range(200));
      endcase
      if (sel < 50) begin
         if (gen_count < steq_pkg::QDEPTH) begin
            gen_hnd[gen_count] = h; gen_dat[gen_count] = d; gen_count++;
         end
         pending_reqs.push_back(make_req(steq_pkg::OP_ADD, dly, h, d, rnd_time));
      end else if (sel < 62) begin
         if ($urandom_range(1) == 0) h = '0;
         pending_reqs.push_back(make_req(steq_pkg::OP_CANCEL, rnd_dly, h, d, rnd_time));
      end else if (sel < 82) begin
         case ($urandom_range(5))
            0: t = $urandom;
            1: t = gen_time - $urandom_range(300);
            default: t = gen_time + $urandom_range(400);
         endcase
         gen_time = t;
         gen_count = 0;
         pending_reqs.push_back(make_req(steq_pkg::OP_ADVANCE, rnd_dly, h, d, t));
      end else begin
         pending_reqs.push_back(make_req(steq_pkg::OP_QUERY, rnd_dly, h, d, rnd_time));
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0 ||
             hold_off || hold_cycles > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      logic [steq_pkg::TIME_W-1:0] gen_time;
      gen_time = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, wrap, backward time, saturation, full queue
      pending_reqs.push_back(make_req(steq_pkg::OP_QUERY, '0, '0, '0, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADD, 24'hFF_FFFF, 4'hF, 16'hFFFF,
                                      32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADD, '0, '0, 16'h0000, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADD, '0, 4'h5, 16'h1234, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_QUERY, '0, 4'hF, 16'hFFFF, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_QUERY, '0, 4'h0, 16'h1234, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_CANCEL, '0, '0, 16'h1234, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADVANCE, '0, '0, '0, 32'hFFFF_FFF0));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADD, 24'h00_0100, 4'h3, 16'hAAAA, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADD, 24'h00_0005, 4'h0, 16'h5555, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_QUERY, '0, 4'h3, 16'hAAAA, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADVANCE, '0, '0, '0, 32'h0000_0010));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADVANCE, '0, '0, '0, 32'h0000_0000));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADD, 24'hFF_FFFF, 4'h1, 16'h0001, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADVANCE, '0, '0, '0, 32'hFF00_0000));
      pending_reqs.push_back(make_req(steq_pkg::OP_QUERY, '0, 4'h1, 16'h0001, '0));
      for (int i = 0; i < 34; i++)
         pending_reqs.push_back(make_req(steq_pkg::OP_ADD, i[steq_pkg::DLY_W-1:0] & 24'h3,
                                         4'h2, 16'h00AB, '0));
      pending_reqs.push_back(make_req(steq_pkg::OP_ADVANCE, '0, '0, '0, 32'hFFFF_FFFF));
      wait_drained();

      // Random phases with different idle/stall mixes
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 48 : (ph == 3) ? 32 : 0;
         recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 32 : 0;
         if (ph == 2) hold_off = 1'b1;
         for (int n = 0; n < 70; n++) push_random_item(gen_time);
         wait_drained();
      end

      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
